[rtl/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and depth decode for the packed sample unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SELECT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_LINE = 2'd2;

  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_6  = 3'd3;
  localparam logic [2:0] DEPTH_8  = 3'd4;
  localparam logic [2:0] DEPTH_16 = 3'd5;

  typedef struct packed {
    logic [2:0]             depth_select;
    logic                   invert_enable;
    logic [CFG_WIDTH-1:0]   samples_per_line;
  } cfg_t;

  // Sample width in bits; unused codes behave as eight bits.
  function automatic logic [4:0] depth_bits(input logic [2:0] sel);
    logic [4:0] bits;
    unique case (sel)
      DEPTH_1:  bits = 5'd1;
      DEPTH_2:  bits = 5'd2;
      DEPTH_4:  bits = 5'd4;
      DEPTH_6:  bits = 5'd6;
      DEPTH_16: bits = 5'd16;
      default:  bits = 5'd8;
    endcase
    return bits;
  endfunction

  function automatic logic [15:0] depth_mask(input logic [2:0] sel);
    logic [15:0] mask;
    unique case (sel)
      DEPTH_1:  mask = 16'h0001;
      DEPTH_2:  mask = 16'h0003;
      DEPTH_4:  mask = 16'h000F;
      DEPTH_6:  mask = 16'h003F;
      DEPTH_16: mask = 16'hFFFF;
      default:  mask = 16'h00FF;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

[rtl/packed_sample_unpack_core.sv]
// ----------------------------------------------------------------------------
// packed_sample_unpack_core
// Unpacks MSB-first packed bytes into 1 to 16-bit samples.
// ----------------------------------------------------------------------------
// Bytes enter a two-entry queue; the extraction engine takes one sample per
// cycle, while the output is not stalled, from the byte at its head and
// places it in an output register; a byte yields one to eight samples, or
// none if it only adds to the held bits. Samples leave at up to one per
// cycle while the output is not stalled. Configuration must be written
// only while no transaction is in flight; a write to depth_select realigns
// the unpacker to a byte boundary and restarts the row count.
`default_nettype none

module packed_sample_unpack_core
  import psu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               out_sample_value,
  output logic                      out_last_of_item,
  output logic                      out_last_of_line
);

  cfg_t       cfg_r, cfg_nxt;
  logic       row_clear;
  logic       q_valid;
  logic [7:0] q_data;
  logic       q_pop;

  assign row_clear = cfg_we && (cfg_index == CFG_DEPTH_SELECT);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH_SELECT:     cfg_nxt.depth_select     = cfg_wdata[2:0];
        CFG_INVERT_ENABLE:    cfg_nxt.invert_enable    = cfg_wdata[0];
        CFG_SAMPLES_PER_LINE: cfg_nxt.samples_per_line = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_select     <= DEPTH_8;
      cfg_r.invert_enable    <= 1'b0;
      cfg_r.samples_per_line <= {{(CFG_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  psu_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  psu_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .row_clear        (row_clear),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_last_of_item (out_last_of_item),
    .out_last_of_line (out_last_of_line)
  );

endmodule

`default_nettype wire

[rtl/psu_queue.sv]
// ----------------------------------------------------------------------------
// psu_queue
// Two-entry intake queue that accepts packed bytes from the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue
  import psu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  output logic            q_valid,
  output logic [7:0]      q_data,
  input  wire logic       q_pop
);

  logic [7:0] mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign in_stall = (count_r == 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data_byte;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !pop) |=> (count_r == 2'd2))
    else $error("queue lost an entry while full");

endmodule

`default_nettype wire

[rtl/psu_engine.sv]
// ----------------------------------------------------------------------------
// psu_engine
// Extracts samples from queued bytes, one per unstalled cycle, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_engine
  import psu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        row_clear,
  input  wire logic        q_valid,
  input  wire logic [7:0]  q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_sample_value,
  output logic             out_last_of_item,
  output logic             out_last_of_line
);

  logic [7:0]             held_bits_r, held_bits_nxt;
  logic [3:0]             held_count_r, held_count_nxt;
  logic [COUNT_WIDTH-1:0] sample_index_r, sample_index_nxt;
  logic                   busy_r, busy_nxt;
  logic [15:0]            acc_r, acc_nxt;
  logic [4:0]             n_r, n_nxt;
  logic [2:0]             k_r, k_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [15:0]            out_sample_r, out_sample_nxt;
  logic                   out_item_r, out_item_nxt;
  logic                   out_line_r, out_line_nxt;

  logic [4:0]             d_bits;
  logic [15:0]            d_mask;
  logic [3:0]             hc_clamped;
  logic [15:0]            cur_acc;
  logic [4:0]             cur_n;
  logic [2:0]             cur_k;
  logic                   have;
  logic                   can_emit;
  logic                   out_free;
  logic                   emit;
  logic [4:0]             shift_amt;
  logic [4:0]             n_rem;
  logic [15:0]            sample;
  logic [COUNT_WIDTH-1:0] next_index;
  logic                   eol;
  logic                   last_item;
  logic [4:0]             n_fin;
  logic [7:0]             keep_mask;
  logic                   finish;

  assign d_bits     = depth_bits(cfg.depth_select);
  assign d_mask     = depth_mask(cfg.depth_select);
  assign hc_clamped = (held_count_r > 4'd8) ? 4'd8 : held_count_r;
  assign cur_acc    = busy_r ? acc_r : {held_bits_r, q_data};
  assign cur_n      = busy_r ? n_r : ({1'b0, hc_clamped} + 5'd8);
  assign cur_k      = busy_r ? k_r : 3'd0;
  assign have       = busy_r || q_valid;
  assign can_emit   = have && (cur_n >= d_bits);
  assign out_free   = !out_valid_r || !out_stall;
  assign emit       = can_emit && out_free;
  assign shift_amt  = cur_n - d_bits;
  assign n_rem      = cur_n - d_bits;
  assign sample     = ((cur_acc >> shift_amt) & d_mask) ^ (cfg.invert_enable ? d_mask : 16'h0);
  assign next_index = sample_index_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign eol        = (next_index != '0)
                      ? (32'(next_index) >= 32'(cfg.samples_per_line))
                      : (cfg.samples_per_line == '0);
  assign last_item  = eol || (n_rem < d_bits) || (cur_k == 3'd7);
  assign finish     = (have && !can_emit) || (emit && last_item);
  assign n_fin      = !can_emit ? cur_n : (eol ? 5'd0 : n_rem);
  assign keep_mask  = (n_fin >= 5'd8) ? 8'hFF : ~(8'hFF << n_fin[2:0]);
  assign q_pop      = !busy_r && q_valid && (!can_emit || out_free);

  always_comb begin
    held_bits_nxt    = held_bits_r;
    held_count_nxt   = held_count_r;
    sample_index_nxt = sample_index_r;
    busy_nxt         = busy_r;
    acc_nxt          = acc_r;
    n_nxt            = n_r;
    k_nxt            = k_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_sample_nxt   = out_sample_r;
    out_item_nxt     = out_item_r;
    out_line_nxt     = out_line_r;
    if (emit) begin
      out_valid_nxt    = 1'b1;
      out_sample_nxt   = sample;
      out_item_nxt     = last_item;
      out_line_nxt     = eol;
      sample_index_nxt = eol ? '0 : next_index;
      acc_nxt          = cur_acc;
      n_nxt            = n_rem;
      k_nxt            = cur_k + 3'd1;
      busy_nxt         = !last_item;
    end
    if (finish) begin
      busy_nxt       = 1'b0;
      held_count_nxt = n_fin[3:0];
      held_bits_nxt  = cur_acc[7:0] & keep_mask;
    end
    if (row_clear) begin
      held_bits_nxt    = '0;
      held_count_nxt   = '0;
      sample_index_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bits_r    <= '0;
      held_count_r   <= '0;
      sample_index_r <= '0;
      busy_r         <= 1'b0;
      k_r            <= '0;
      n_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      held_bits_r    <= held_bits_nxt;
      held_count_r   <= held_count_nxt;
      sample_index_r <= sample_index_nxt;
      busy_r         <= busy_nxt;
      k_r            <= k_nxt;
      n_r            <= n_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    out_sample_r <= out_sample_nxt;
    out_item_r   <= out_item_nxt;
    out_line_r   <= out_line_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_last_of_item = out_item_r;
  assign out_last_of_line = out_line_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r != 3'd0))
    else $error("engine busy without a sample taken from the current byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_line_r) |-> out_item_r)
    else $error("end of row not marked as last sample of the byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && eol) |=> (sample_index_r == '0 && !busy_r))
    else $error("row end did not realign the unpacker");

endmodule

`default_nettype wire

[dv/psu_sample_checker.sv]
// ----------------------------------------------------------------------------
// psu_sample_checker
// Predicts and checks every sample leaving the packed sample unpacker.
// ----------------------------------------------------------------------------
// Follows register writes and accepted input bytes, keeps its own copy of the
// held bits and the row position, and compares each accepted output
// transaction, field by field, with the oldest predicted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module psu_sample_checker
  import psu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [15:0]          out_sample_value,
  input  logic                 out_last_of_item,
  input  logic                 out_last_of_line,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  typedef struct packed {
    logic [15:0] value;
    logic        last_of_item;
    logic        last_of_line;
  } sample_t;

  logic [2:0]             depth_sel    = DEPTH_8;
  logic                   invert_on    = 1'b0;
  logic [CFG_WIDTH-1:0]   line_len     = 16'd1;
  logic [7:0]             held_bits    = 8'h00;
  logic [3:0]             held_count   = 4'd0;
  logic [COUNT_WIDTH-1:0] sample_index = '0;

  sample_t expected_samples[$];
  sample_t want;
  int      mismatches = 0;
  int      compared   = 0;
  int      queued     = 0;

  assign fail_count = mismatches;
  assign pending    = queued;
  assign checked    = compared;

  function automatic logic [4:0] sample_bits(input logic [2:0] sel);
    logic [4:0] bits;
    case (sel)
      DEPTH_1:  bits = 5'd1;
      DEPTH_2:  bits = 5'd2;
      DEPTH_4:  bits = 5'd4;
      DEPTH_6:  bits = 5'd6;
      DEPTH_16: bits = 5'd16;
      default:  bits = 5'd8;
    endcase
    return bits;
  endfunction

  function automatic void unpack_byte(input logic [7:0] data);
    sample_t                batch [8];
    logic [4:0]             bits;
    logic [15:0]            mask;
    logic [15:0]            acc;
    logic [15:0]            s;
    logic [COUNT_WIDTH-1:0] next_index;
    logic                   row_done;
    int                     n;
    int                     k;
    int                     i;
    bits = sample_bits(depth_sel);
    mask = (bits == 5'd16) ? 16'hFFFF : ((16'd1 << bits) - 16'd1);
    n = (held_count > 4'd8) ? 16 : int'(held_count) + 8;
    acc = {held_bits, data};
    k = 0;
    row_done = 1'b0;
    while (n >= int'(bits) && k < 8 && !row_done) begin
      s = (acc >> (n - int'(bits))) & mask;
      if (invert_on) begin
        s = s ^ mask;
      end
      n = n - int'(bits);
      next_index = sample_index + 1'b1;
      if (next_index != '0) begin
        row_done = (next_index >= line_len);
      end else begin
        row_done = (line_len == '0);
      end
      batch[k].value = s;
      batch[k].last_of_item = 1'b0;
      batch[k].last_of_line = row_done;
      k++;
      if (row_done) begin
        sample_index = '0;
        n = 0;
      end else begin
        sample_index = next_index;
      end
    end
    held_count = 4'(n);
    held_bits = (n == 0) ? 8'h00 : 8'(acc & ((16'd1 << n) - 16'd1));
    if (k > 0) begin
      batch[k-1].last_of_item = 1'b1;
    end
    for (i = 0; i < k; i++) begin
      expected_samples.push_back(batch[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_sel = DEPTH_8;
      invert_on = 1'b0;
      line_len = 16'd1;
      held_bits = 8'h00;
      held_count = 4'd0;
      sample_index = '0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample transaction: sample_value %04h", out_sample_value);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          compared++;
          if (out_sample_value !== want.value) begin
            $error("sample_value mismatch: expected %04h, got %04h",
                   want.value, out_sample_value);
            mismatches++;
          end
          if (out_last_of_item !== want.last_of_item) begin
            $error("last_of_item mismatch: expected %0b, got %0b",
                   want.last_of_item, out_last_of_item);
            mismatches++;
          end
          if (out_last_of_line !== want.last_of_line) begin
            $error("last_of_line mismatch: expected %0b, got %0b",
                   want.last_of_line, out_last_of_line);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        unpack_byte(in_data_byte);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPTH_SELECT: begin
            depth_sel = cfg_wdata[2:0];
            held_bits = 8'h00;
            held_count = 4'd0;
            sample_index = '0;
          end
          CFG_INVERT_ENABLE: begin
            invert_on = cfg_wdata[0];
          end
          CFG_SAMPLES_PER_LINE: begin
            line_len = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
    queued = expected_samples.size();
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the packed sample unpacker.
// ----------------------------------------------------------------------------
// Drives packed bytes under a series of register settings, first a directed
// set of corner cases and then random rows, with random pauses on the input
// and random back-pressure on the output. A separate checker predicts every
// sample; this module produces stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import psu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_BYTES    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_DEPTH_SELECT;
  logic [CFG_WIDTH-1:0] cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [15:0]          out_sample_value;
  logic                 out_last_of_item;
  logic                 out_last_of_line;

  int fail_count;
  int pending;
  int checked;
  int bytes_sent = 0;
  int reg_writes = 0;
  int stuck      = 0;
  bit quiet      = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  packed_sample_unpack_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_last_of_item (out_last_of_item),
    .out_last_of_line (out_last_of_line)
  );

  psu_sample_checker sample_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_last_of_item (out_last_of_item),
    .out_last_of_line (out_last_of_line),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom());
  endfunction

  function automatic logic [CFG_WIDTH-1:0] random_line_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 16'd0;
    end else if (r == 1) begin
      return 16'd1;
    end else if (r == 2) begin
      return 16'hFFFF;
    end else if (r < 7) begin
      return 16'($urandom_range(2, 12));
    end
    return 16'($urandom_range(13, 300));
  endfunction

  // Upper bits of the write data are ignored, so they are sometimes filled.
  function automatic logic [CFG_WIDTH-1:0] with_noise(input logic [CFG_WIDTH-1:0] value,
                                                     input int keep);
    logic [CFG_WIDTH-1:0] word;
    word = value;
    if ($urandom_range(0, 3) == 0) begin
      word = 16'($urandom());
      word = (word & ~((16'd1 << keep) - 16'd1)) | value;
    end
    return word;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_WIDTH-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      out_stall <= 1'b0;
      repeat (1 + $urandom_range(0, 12)) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat (pause_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= WATCHDOG_LIMIT) begin
          $display("packed_sample_unpack_core regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one 8-bit sample per byte, each ending a row.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    settle();

    // A zero row length behaves as one, so the rest of the byte is dropped.
    write_reg(CFG_DEPTH_SELECT, {13'd0, DEPTH_1});
    write_reg(CFG_SAMPLES_PER_LINE, 16'd0);
    push_byte(8'hC3);
    settle();

    write_reg(CFG_SAMPLES_PER_LINE, 16'd16);
    write_reg(CFG_INVERT_ENABLE, 16'd1);
    push_byte(8'h5A);
    push_byte(8'hFF);
    settle();

    write_reg(CFG_DEPTH_SELECT, {13'd0, DEPTH_2});
    write_reg(CFG_INVERT_ENABLE, 16'd0);
    write_reg(CFG_SAMPLES_PER_LINE, 16'hFFFF);
    push_byte(8'h1B);
    push_byte(8'hE4);
    settle();

    write_reg(CFG_DEPTH_SELECT, {13'd0, DEPTH_4});
    push_byte(8'h0F);
    push_byte(8'hF0);
    settle();

    // Six-bit samples straddle bytes; the row ends inside the fourth byte.
    write_reg(CFG_DEPTH_SELECT, {13'd0, DEPTH_6});
    write_reg(CFG_SAMPLES_PER_LINE, 16'd5);
    push_byte(8'hFC);
    push_byte(8'h0F);
    push_byte(8'hFF);
    push_byte(8'h81);
    settle();

    // Row length lowered part-way through a row ends it on the next sample.
    write_reg(CFG_SAMPLES_PER_LINE, 16'd100);
    push_byte(8'h12);
    push_byte(8'h34);
    settle();
    write_reg(CFG_SAMPLES_PER_LINE, 16'd1);
    push_byte(8'h56);
    settle();

    // Inversion switched on part-way through a row keeps the held bits.
    write_reg(CFG_SAMPLES_PER_LINE, 16'd100);
    push_byte(8'h78);
    settle();
    write_reg(CFG_INVERT_ENABLE, 16'd1);
    push_byte(8'h9A);
    settle();

    // Sixteen-bit samples: the first byte of each yields nothing.
    write_reg(CFG_DEPTH_SELECT, {13'd0, DEPTH_16});
    write_reg(CFG_SAMPLES_PER_LINE, 16'd2);
    push_byte(8'hAB);
    push_byte(8'hCD);
    push_byte(8'h00);
    push_byte(8'hFF);
    settle();

    // A depth write realigns even when the depth does not change.
    write_reg(CFG_INVERT_ENABLE, 16'd0);
    push_byte(8'h12);
    settle();
    write_reg(CFG_DEPTH_SELECT, {13'd0, DEPTH_16});
    push_byte(8'h34);
    push_byte(8'h56);
    settle();

    // The two unused depth codes behave as eight bits.
    write_reg(CFG_DEPTH_SELECT, 16'hFFFE);
    push_byte(8'h3C);
    settle();
    write_reg(CFG_DEPTH_SELECT, 16'h0007);
    write_reg(CFG_SPARE_INDEX, 16'($urandom()));
    push_byte(8'hC3);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_DEPTH_SELECT, with_noise(16'($urandom_range(0, 7)), 3));
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_INVERT_ENABLE, with_noise(16'($urandom_range(0, 1)), 1));
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_SAMPLES_PER_LINE, random_line_len());
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_SPARE_INDEX, 16'($urandom()));
      end
      for (int i = 0; i < PHASE_BYTES; i++) begin
        push_byte(random_byte());
      end
      settle();
    end

    $display("Summary: %0d bytes in, %0d register writes, %0d samples compared.",
             bytes_sent, reg_writes, checked);
    $display("Depths of 1 to 16 bits, inversion, zero and full row lengths were covered.");
    if (fail_count == 0 && pending == 0) begin
      $display("packed_sample_unpack_core regression: pass");
    end else begin
      $display("packed_sample_unpack_core regression: fail");
    end
    $finish;
  end

endmodule
